// ===== rtl/core/vwbp_pkg.sv =====
// Shared types and constants for the variable-width bit packer.
`default_nettype none

package vwbp_pkg;

  localparam int BYTE_BITS  = 8;
  localparam int CODE_W     = 32;
  localparam int COUNT_W    = 6;
  localparam int TOTAL_W    = 32;
  localparam int PEND_CNT_W = 3;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]   bytes_written;
    logic                 last_of_run;
    logic [BYTE_BITS-1:0] out_byte;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/vwbp_out_slot.sv =====
// Single-entry output register for packed bytes on the master-side stream.
`default_nettype none

module vwbp_out_slot (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  vwbp_pkg::out_item_t   item,
  output logic                  free,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output vwbp_pkg::out_item_t   slot
);
  import vwbp_pkg::*;

  logic full;

  // slot can take a new item when empty or when the held one leaves this cycle
  assign free          = !full || m_axis_tready;
  assign m_axis_tvalid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (m_axis_tready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/variable_width_bit_packer.sv =====
// Bit-serial packer: one appended bit per cycle while the output register can take a filled byte; bytes fill MSB first.
// Append of n bits: accepted in idle, then one code bit shifted in per ST_SHIFT step (n saturated to MAX_CODE_BITS).
// Flush: accepted in idle, then ST_FLUSH writes the pending byte; with nothing pending, no flush step.
// A filled byte is loaded into the output register as its last bit is shifted in, and is valid in the next cycle.
// A new item is taken only in idle, once the last one is done; stalls while the output register cannot take a byte.
// Reset (rst, synchronous): clears pending bits, bit count, byte total and output valid.
`default_nettype none

module variable_width_bit_packer #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [5:0] bit_count, [37:6] code_value, [39:38] zero
  input  logic        s_axis_tuser,  // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [7:0] out_byte, [39:8] bytes_written
  output logic        m_axis_tlast
);
  import vwbp_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_CODE_BITS);

  state_t                state, state_next;
  logic [BYTE_BITS-1:0]  pend_bits, pend_bits_next;
  logic [PEND_CNT_W-1:0] pend_cnt, pend_cnt_next;
  logic [TOTAL_W-1:0]    byte_total, byte_total_next;
  logic [CODE_W-1:0]     code_sr, code_sr_next;
  logic [COUNT_W-1:0]    bits_left, bits_left_next;

  logic                  in_accept;
  logic [COUNT_W-1:0]    in_count;
  logic [COUNT_W-1:0]    sat_count;
  logic [CODE_W-1:0]     in_value;
  cmd_t                  in_cmd;
  logic [BYTE_BITS-1:0]  ins_bits;
  logic                  slot_free;
  logic                  slot_load;
  out_item_t             slot_item;
  out_item_t             slot_q;

  assign in_count  = s_axis_tdata[COUNT_W-1:0];
  assign in_value  = s_axis_tdata[COUNT_W+CODE_W-1:COUNT_W];
  assign in_cmd    = cmd_t'(s_axis_tuser);
  assign sat_count = (in_count > MaxCount) ? MaxCount : in_count;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // place the next code bit at the highest free position
  assign ins_bits = pend_bits |
                    (BYTE_BITS'(code_sr[0]) << (3'(BYTE_BITS - 1) - pend_cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_bits  <= '0;
      pend_cnt   <= '0;
      byte_total <= '0;
      bits_left  <= '0;
    end else begin
      state      <= state_next;
      pend_bits  <= pend_bits_next;
      pend_cnt   <= pend_cnt_next;
      byte_total <= byte_total_next;
      bits_left  <= bits_left_next;
    end
  end

  always_ff @(posedge clk) begin
    code_sr <= code_sr_next;
  end

  always_comb begin
    state_next      = state;
    pend_bits_next  = pend_bits;
    pend_cnt_next   = pend_cnt;
    byte_total_next = byte_total;
    code_sr_next    = code_sr;
    bits_left_next  = bits_left;
    slot_load       = 1'b0;
    slot_item       = '{bytes_written: byte_total + 1'b1, last_of_run: 1'b1,
                        out_byte: pend_bits};

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_cmd == CMD_FLUSH) begin
            if (pend_cnt != '0) begin
              state_next = ST_FLUSH;
            end
          end else begin
            code_sr_next   = in_value;
            bits_left_next = sat_count;
            if (sat_count != '0) begin
              state_next = ST_SHIFT;
            end
          end
        end
      end

      ST_SHIFT: begin
        // hold when this bit fills a byte and the output register is busy
        if (pend_cnt != 3'(BYTE_BITS - 1) || slot_free) begin
          code_sr_next   = code_sr >> 1;
          bits_left_next = bits_left - 1'b1;
          if (pend_cnt == 3'(BYTE_BITS - 1)) begin
            slot_load             = 1'b1;
            slot_item.out_byte    = ins_bits;
            slot_item.last_of_run = (bits_left <= COUNT_W'(BYTE_BITS));
            byte_total_next       = byte_total + 1'b1;
            pend_bits_next        = '0;
            pend_cnt_next         = '0;
          end else begin
            pend_bits_next = ins_bits;
            pend_cnt_next  = pend_cnt + 1'b1;
          end
          if (bits_left == COUNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        if (slot_free) begin
          slot_load       = 1'b1;
          byte_total_next = byte_total + 1'b1;
          pend_bits_next  = '0;
          pend_cnt_next   = '0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  vwbp_out_slot u_out_slot (
    .clk           (clk),
    .rst           (rst),
    .load          (slot_load),
    .item          (slot_item),
    .free          (slot_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .slot          (slot_q)
  );

  assign m_axis_tdata = {slot_q.bytes_written, slot_q.out_byte};
  assign m_axis_tlast = slot_q.last_of_run;

endmodule

`default_nettype wire
